// ===== rtl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg: splice insert parser package
// Field codes, parse phases and the result record shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  localparam int MAX_COMPONENTS_DEF = 32;
  localparam int RESULT_SLOTS       = 4;

  typedef enum logic [4:0] {
    FC_EVENT_ID       = 5'd0,
    FC_CANCEL         = 5'd1,
    FC_OUT_OF_NETWORK = 5'd2,
    FC_PROGRAM_SPLICE = 5'd3,
    FC_DURATION_FLAG  = 5'd4,
    FC_IMMEDIATE      = 5'd5,
    FC_TIME_FLAG      = 5'd6,
    FC_PTS            = 5'd7,
    FC_COMP_COUNT     = 5'd8,
    FC_COMP_TAG       = 5'd9,
    FC_COMP_TIME_FLAG = 5'd10,
    FC_COMP_PTS       = 5'd11,
    FC_AUTO_RETURN    = 5'd12,
    FC_BREAK_DURATION = 5'd13,
    FC_PROGRAM_ID     = 5'd14,
    FC_AVAIL_NUM      = 5'd15,
    FC_AVAILS_EXP     = 5'd16
  } field_code_t;

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_EVID   = 12'b0000_0000_0010,
    PH_CANCEL = 12'b0000_0000_0100,
    PH_FLAGS  = 12'b0000_0000_1000,
    PH_PTIME  = 12'b0000_0001_0000,
    PH_CCOUNT = 12'b0000_0010_0000,
    PH_CTAG   = 12'b0000_0100_0000,
    PH_CTIME  = 12'b0000_1000_0000,
    PH_BREAK  = 12'b0001_0000_0000,
    PH_PROGID = 12'b0010_0000_0000,
    PH_AVNUM  = 12'b0100_0000_0000,
    PH_AVEXP  = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    field_code_t  code;
    logic [32:0]  value;
    logic [7:0]   index;
    logic [11:0]  offset;
    logic [10:0]  used;
    logic         last;
  } result_t;

  function automatic result_t mk_result(field_code_t code, logic [32:0] value,
                                        logic [7:0] index, logic [11:0] offset);
    result_t r;
    r.code   = code;
    r.value  = value;
    r.index  = index;
    r.offset = offset;
    r.used   = '0;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sip_in_if.sv =====
// ----------------------------------------------------------------------------
// sip_in_if: command byte channel
// Valid/ready channel carrying one command byte with its start mark and offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface sip_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [11:0] byte_position;

  modport source (output valid, data_byte, start_req, byte_position, input ready);
  modport sink   (input valid, data_byte, start_req, byte_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/sip_out_if.sv =====
// ----------------------------------------------------------------------------
// sip_out_if: decoded field channel
// Valid/ready channel carrying one decoded splice insert field.
// ----------------------------------------------------------------------------
`default_nettype none

interface sip_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [32:0] field_value;
  logic [7:0]  component_index;
  logic [11:0] time_byte_offset;
  logic [10:0] bytes_used;
  logic        last;

  modport source (output valid, field_code, field_value, component_index,
                  time_byte_offset, bytes_used, last, input ready);
  modport sink   (input valid, field_code, field_value, component_index,
                  time_byte_offset, bytes_used, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/splice_insert_parser.sv =====
// Flow: an accepted byte is held in the input register, then decoded into the
// result bank, from which the fields are offered in order.
// Throughput: 1 byte per cycle while the result bank empties in time; a byte
// giving several fields holds the input while the 4-entry result bank drains one
// field per cycle while field.ready is high (the flags byte gives four).
// Reset: synchronous, active high; parser returns to idle, all banks empty.
// ----------------------------------------------------------------------------
// splice_insert_parser: splice insert command decoder
// Byte-serial parse of a splice insert command into coded field items.
// ----------------------------------------------------------------------------
`default_nettype none

module splice_insert_parser #(
  parameter int MAX_COMPONENTS = sip_pkg::MAX_COMPONENTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sip_in_if.sink     cmd,
  sip_out_if.source  field
);
  import sip_pkg::*;

  localparam int FLG_IMM  = 0;
  localparam int FLG_DUR  = 1;
  localparam int FLG_PROG = 2;
  localparam logic [10:0] USED_MAX = 11'h7ff;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic [11:0] in_pos;

  // parser state
  phase_t      phase;
  logic [2:0]  byte_in_field;
  logic [32:0] accumulator;
  logic [3:0]  command_flags;
  logic [7:0]  components_left;
  logic [7:0]  component_number;
  logic [10:0] consumed_count;
  logic [11:0] time_offset;

  phase_t      phase_next;
  logic [2:0]  byte_in_field_next;
  logic [32:0] accumulator_next;
  logic [3:0]  command_flags_next;
  logic [7:0]  components_left_next;
  logic [7:0]  component_number_next;
  logic [10:0] consumed_count_next;
  logic [11:0] time_offset_next;

  // current view after a start byte
  phase_t      ph_cur;
  logic [2:0]  bif_cur;
  logic [32:0] acc_cur;
  logic [3:0]  flags_cur;
  logic [7:0]  left_cur;
  logic [7:0]  num_cur;
  logic [10:0] used_cur;
  logic [11:0] toff_cur;

  logic [32:0] acc_sh;
  logic [7:0]  num_inc;
  logic [7:0]  left_dec;
  phase_t      after_ph;
  phase_t      done_ph;
  logic        rep;
  logic        comp;
  logic [7:0]  idx;
  logic [3:0]  new_flags;
  logic        run;

  // result bank
  result_t     res [RESULT_SLOTS];
  result_t     res_new [RESULT_SLOTS];
  logic [2:0]  cnt;
  logic [2:0]  cnt_new;
  logic [1:0]  head;

  logic        advance;
  logic        out_fire;
  logic        bank_free;

  assign out_fire  = field.valid && field.ready;
  assign bank_free = (cnt == 3'd0) || (out_fire && ({1'b0, head} + 3'd1 == cnt));
  assign advance   = in_valid && bank_free;
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_byte  <= cmd.data_byte;
      in_start <= cmd.start_req;
      in_pos   <= cmd.byte_position;
    end
  end

  always_comb begin
    ph_cur    = in_start ? PH_EVID : phase;
    bif_cur   = in_start ? 3'd0 : byte_in_field;
    acc_cur   = in_start ? 33'd0 : accumulator;
    flags_cur = in_start ? 4'd0 : command_flags;
    left_cur  = in_start ? 8'd0 : components_left;
    num_cur   = in_start ? 8'd0 : component_number;
    used_cur  = in_start ? 11'd0 : consumed_count;
    toff_cur  = in_start ? 12'd0 : time_offset;
    run       = in_start || (phase != PH_IDLE);

    acc_sh    = {acc_cur[24:0], in_byte};
    num_inc   = (num_cur != 8'hff) ? num_cur + 8'd1 : num_cur;
    left_dec  = (left_cur != 8'd0) ? left_cur - 8'd1 : 8'd0;
    after_ph  = flags_cur[FLG_DUR] ? PH_BREAK : PH_PROGID;
    done_ph   = (left_dec == 8'd0) ? after_ph : PH_CTAG;
    rep       = ({1'b0, num_cur} < 9'(MAX_COMPONENTS));
    comp      = (ph_cur == PH_CTIME);
    idx       = comp ? num_cur : 8'd0;
    new_flags = in_byte[7:4];

    phase_next            = phase;
    byte_in_field_next    = byte_in_field;
    accumulator_next      = accumulator;
    command_flags_next    = command_flags;
    components_left_next  = components_left;
    component_number_next = component_number;
    consumed_count_next   = consumed_count;
    time_offset_next      = time_offset;
    cnt_new               = 3'd0;
    for (int i = 0; i < RESULT_SLOTS; i++) res_new[i] = '0;

    if (run) begin
      phase_next            = ph_cur;
      byte_in_field_next    = bif_cur;
      accumulator_next      = acc_cur;
      command_flags_next    = flags_cur;
      components_left_next  = left_cur;
      component_number_next = num_cur;
      time_offset_next      = toff_cur;
      consumed_count_next   = (used_cur != USED_MAX) ? used_cur + 11'd1 : used_cur;

      unique case (ph_cur)
        PH_EVID: begin
          accumulator_next   = acc_sh;
          byte_in_field_next = bif_cur + 3'd1;
          if (bif_cur + 3'd1 >= 3'd4) begin
            res_new[0] = mk_result(FC_EVENT_ID, {1'b0, acc_sh[31:0]}, 8'd0, 12'd0);
            cnt_new            = 3'd1;
            phase_next         = PH_CANCEL;
            byte_in_field_next = 3'd0;
            accumulator_next   = '0;
          end
        end
        PH_CANCEL: begin
          res_new[0] = mk_result(FC_CANCEL, {32'd0, in_byte[7]}, 8'd0, 12'd0);
          cnt_new            = 3'd1;
          phase_next         = in_byte[7] ? PH_PROGID : PH_FLAGS;
          byte_in_field_next = 3'd0;
          accumulator_next   = '0;
        end
        PH_FLAGS: begin
          command_flags_next = new_flags;
          res_new[0] = mk_result(FC_OUT_OF_NETWORK, {32'd0, in_byte[7]}, 8'd0, 12'd0);
          res_new[1] = mk_result(FC_PROGRAM_SPLICE, {32'd0, in_byte[6]}, 8'd0, 12'd0);
          res_new[2] = mk_result(FC_DURATION_FLAG, {32'd0, in_byte[5]}, 8'd0, 12'd0);
          res_new[3] = mk_result(FC_IMMEDIATE, {32'd0, in_byte[4]}, 8'd0, 12'd0);
          cnt_new            = 3'd4;
          byte_in_field_next = 3'd0;
          accumulator_next   = '0;
          if (new_flags[FLG_PROG] && !new_flags[FLG_IMM]) begin
            phase_next = PH_PTIME;
          end else if (!new_flags[FLG_PROG]) begin
            phase_next = PH_CCOUNT;
          end else begin
            phase_next = new_flags[FLG_DUR] ? PH_BREAK : PH_PROGID;
          end
        end
        PH_PTIME, PH_CTIME: begin
          if (bif_cur == 3'd0) begin
            time_offset_next = in_pos;
            if (!comp || rep) begin
              res_new[0] = mk_result(comp ? FC_COMP_TIME_FLAG : FC_TIME_FLAG,
                                     {32'd0, in_byte[7]}, idx, in_pos);
              cnt_new = 3'd1;
            end
            if (in_byte[7]) begin
              accumulator_next   = {32'd0, in_byte[0]};
              byte_in_field_next = 3'd1;
            end else begin
              byte_in_field_next = 3'd0;
              accumulator_next   = '0;
              if (comp) begin
                component_number_next = num_inc;
                components_left_next  = left_dec;
                phase_next            = done_ph;
              end else begin
                phase_next = after_ph;
              end
            end
          end else begin
            accumulator_next   = acc_sh;
            byte_in_field_next = bif_cur + 3'd1;
            if (bif_cur + 3'd1 >= 3'd5) begin
              if (!comp || rep) begin
                res_new[0] = mk_result(comp ? FC_COMP_PTS : FC_PTS, acc_sh, idx, toff_cur);
                cnt_new = 3'd1;
              end
              byte_in_field_next = 3'd0;
              accumulator_next   = '0;
              if (comp) begin
                component_number_next = num_inc;
                components_left_next  = left_dec;
                phase_next            = done_ph;
              end else begin
                phase_next = after_ph;
              end
            end
          end
        end
        PH_CCOUNT: begin
          res_new[0] = mk_result(FC_COMP_COUNT, {25'd0, in_byte}, 8'd0, 12'd0);
          cnt_new               = 3'd1;
          components_left_next  = in_byte;
          component_number_next = 8'd0;
          if (in_byte == 8'd0) begin
            phase_next         = after_ph;
            byte_in_field_next = 3'd0;
            accumulator_next   = '0;
          end else begin
            phase_next = PH_CTAG;
          end
        end
        PH_CTAG: begin
          if (rep) begin
            res_new[0] = mk_result(FC_COMP_TAG, {25'd0, in_byte}, num_cur, 12'd0);
            cnt_new = 3'd1;
          end
          byte_in_field_next = 3'd0;
          accumulator_next   = '0;
          if (!flags_cur[FLG_IMM]) begin
            phase_next = PH_CTIME;
          end else begin
            component_number_next = num_inc;
            components_left_next  = left_dec;
            phase_next            = done_ph;
          end
        end
        PH_BREAK: begin
          if (bif_cur == 3'd0) begin
            res_new[0] = mk_result(FC_AUTO_RETURN, {32'd0, in_byte[7]}, 8'd0, 12'd0);
            cnt_new            = 3'd1;
            accumulator_next   = {32'd0, in_byte[0]};
            byte_in_field_next = 3'd1;
          end else begin
            accumulator_next   = acc_sh;
            byte_in_field_next = bif_cur + 3'd1;
            if (bif_cur + 3'd1 >= 3'd5) begin
              res_new[0] = mk_result(FC_BREAK_DURATION, acc_sh, 8'd0, 12'd0);
              cnt_new            = 3'd1;
              phase_next         = PH_PROGID;
              byte_in_field_next = 3'd0;
              accumulator_next   = '0;
            end
          end
        end
        PH_PROGID: begin
          accumulator_next   = {17'd0, acc_cur[7:0], in_byte};
          byte_in_field_next = bif_cur + 3'd1;
          if (bif_cur + 3'd1 >= 3'd2) begin
            res_new[0] = mk_result(FC_PROGRAM_ID, {17'd0, acc_cur[7:0], in_byte},
                                   8'd0, 12'd0);
            cnt_new            = 3'd1;
            phase_next         = PH_AVNUM;
            byte_in_field_next = 3'd0;
            accumulator_next   = '0;
          end
        end
        PH_AVNUM: begin
          res_new[0] = mk_result(FC_AVAIL_NUM, {25'd0, in_byte}, 8'd0, 12'd0);
          cnt_new    = 3'd1;
          phase_next = PH_AVEXP;
        end
        PH_AVEXP: begin
          res_new[0] = mk_result(FC_AVAILS_EXP, {25'd0, in_byte}, 8'd0, 12'd0);
          res_new[0].used = consumed_count_next;
          res_new[0].last = 1'b1;
          cnt_new    = 3'd1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_in_field    <= '0;
      accumulator      <= '0;
      command_flags    <= '0;
      components_left  <= '0;
      component_number <= '0;
      consumed_count   <= '0;
      time_offset      <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      byte_in_field    <= byte_in_field_next;
      accumulator      <= accumulator_next;
      command_flags    <= command_flags_next;
      components_left  <= components_left_next;
      component_number <= component_number_next;
      consumed_count   <= consumed_count_next;
      time_offset      <= time_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      head <= '0;
    end else if (advance) begin
      cnt  <= cnt_new;
      head <= '0;
    end else if (out_fire) begin
      if ({1'b0, head} + 3'd1 == cnt) begin
        cnt  <= '0;
        head <= '0;
      end else begin
        head <= head + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < RESULT_SLOTS; i++) res[i] <= res_new[i];
    end
  end

  assign field.valid            = (cnt != 3'd0);
  assign field.field_code       = res[head].code;
  assign field.field_value      = res[head].value;
  assign field.component_index  = res[head].index;
  assign field.time_byte_offset = res[head].offset;
  assign field.bytes_used       = res[head].used;
  assign field.last             = res[head].last;

`ifndef SYNTH
  a_head_in_bank: assert property (@(posedge clk) disable iff (rst)
    cnt != 3'd0 |-> ({1'b0, head} < cnt) && (cnt <= 3'd4))
    else $error("result bank head beyond fill");

  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> field.valid)
    else $error("input stalled with empty result bank");

  a_flags_four: assert property (@(posedge clk) disable iff (rst)
    advance && !in_start && phase == PH_FLAGS |=> cnt == 3'd4 && head == 2'd0)
    else $error("flags byte did not give four fields");

  a_last_code: assert property (@(posedge clk) disable iff (rst)
    field.valid && field.last |-> field.field_code == FC_AVAILS_EXP)
    else $error("last mark on wrong field");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    advance && !in_start && phase == PH_AVEXP |=> phase == PH_IDLE)
    else $error("parser not idle after command end");
`endif

endmodule

`default_nettype wire
